[hw/rtl/pli_pkg.sv]
package pli_pkg;

  localparam int POINTS_MAX_DEF = 64;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int COORD_W   = 32;
  localparam int INDEX_W   = 6;
  localparam int PARAM_W   = 18;
  localparam int CNT_W     = 7;
  localparam int ACT_W     = 2;
  localparam int CFG_IDX_W = 1;

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 96;

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_EVAL  = 2'd2
  } action_t;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSED     = 1'b1;

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

endpackage

[hw/rtl/pli_point_mem.sv]
module pli_point_mem import pli_pkg::*; #(
  parameter int DEPTH = POINTS_MAX_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  point_t                   wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output point_t                   rd_data_a,
  output point_t                   rd_data_b
);

  point_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

[hw/rtl/pli_blend.sv]
module pli_blend import pli_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      mul_en,
  input  logic signed [COORD_W-1:0] a,
  input  logic signed [COORD_W-1:0] b,
  input  logic [FRAC_BITS:0]        f,
  output logic signed [COORD_W-1:0] pos
);

  localparam int TW = FRAC_BITS + 1;
  localparam int PW = COORD_W + TW + 1;
  localparam int SW = COORD_W + 3;
  localparam logic [TW-1:0] ONE_T = TW'(64'd1 << FRAC_BITS);
  localparam logic signed [SW-1:0] MAX_V = {{(SW-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
  localparam logic signed [SW-1:0] MIN_V = {{(SW-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

  logic signed [PW-1:0] prod_a_r;
  logic signed [PW-1:0] prod_b_r;
  logic [TW-1:0]        w_a;
  logic signed [SW-1:0] sum;

  assign w_a = ONE_T - f;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_a_r <= a * $signed({1'b0, w_a});
      prod_b_r <= b * $signed({1'b0, f});
    end
  end

  assign sum = SW'(prod_a_r >>> FRAC_BITS) + SW'(prod_b_r >>> FRAC_BITS);

  always_comb begin
    if (sum > MAX_V) begin
      pos = MAX_V[COORD_W-1:0];
    end else if (sum < MIN_V) begin
      pos = MIN_V[COORD_W-1:0];
    end else begin
      pos = sum[COORD_W-1:0];
    end
  end

endmodule

[hw/rtl/polyline_point_interpolator.sv]
// Channel  Direction  Handshake              Payload
// in_      slave      in_tvalid/in_tready    tdata: index, x, y, z, param; tuser: action
// out_     master     out_tvalid/out_tready  tdata: x, y, z; tuser: status
// cfg_     slave      cfg_valid/cfg_ready    cfg_index, cfg_data
//
// Each request passes through accept, segment address and table access, multiply, and
// result load; the next request is accepted in the cycle after the result loads.
// The rate is set by the single request in flight around the registered table read.
// Reset is synchronous and resets the control, valid and configuration registers; the
// point table needs no clearing pass. A stalled result holds in the output register
// while the next request is taken; a second result waits until the first one leaves.
module polyline_point_interpolator import pli_pkg::*; #(
  parameter int POINTS_MAX = POINTS_MAX_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // index[5:0], point_x[37:6], point_y[69:38], point_z[101:70], curve_param[119:102]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // action[1:0]
  input  logic [ACT_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status[0]
  output logic                  out_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CNT_W-1:0]      cfg_data
);

  localparam int AW   = $clog2(POINTS_MAX);
  localparam int TW   = FRAC_BITS + 1;
  localparam int EW   = PARAM_W + FRAC_BITS;
  localparam int PEW  = TW + CNT_W;
  localparam logic signed [EW-1:0] ONE_E = EW'(64'd1 << FRAC_BITS);
  localparam logic [TW-1:0]        ONE_T = TW'(64'd1 << FRAC_BITS);

  typedef enum logic [1:0] {S_IDLE, S_ADDR, S_MUL, S_DONE} state_t;

  state_t             state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  point_t             out_pt_r, out_pt_nxt;
  logic               out_status_r, out_status_nxt;
  logic [CNT_W-1:0]   num_points_r;
  logic               closed_r;

  logic [ACT_W-1:0]   act_r;
  logic [INDEX_W-1:0] idx_r;
  point_t             wpt_r;
  logic [TW-1:0]      t_r;
  logic [TW-1:0]      f_r;

  logic               in_acc;
  logic               load;
  logic signed [EW-1:0] param_e;
  logic [TW-1:0]      t_in;
  logic [CNT_W-1:0]   n_pts;
  logic [CNT_W-1:0]   n_m1;
  logic [CNT_W-1:0]   scale;
  logic [PEW-1:0]     epar;
  logic [CNT_W-1:0]   pa_raw;
  logic [CNT_W:0]     pb_raw;
  logic [CNT_W-1:0]   pa;
  logic [CNT_W-1:0]   pb;
  logic [PEW-1:0]     f_full;
  logic [TW-1:0]      f_seg;
  logic               idx_ok;
  logic               wr_en;
  logic               rd_en;
  logic [AW-1:0]      addr_a;
  logic [AW-1:0]      addr_b;
  point_t             rd_a;
  point_t             rd_b;
  point_t             blend_pt;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign load      = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    if (num_points_r == '0) begin
      n_pts = CNT_W'(1);
    end else if (int'(num_points_r) > POINTS_MAX) begin
      n_pts = CNT_W'(POINTS_MAX);
    end else begin
      n_pts = num_points_r;
    end
  end

  assign n_m1  = n_pts - CNT_W'(1);
  assign scale = closed_r ? n_pts : n_m1;

  assign param_e = EW'($signed(in_tdata[119:102]));

  always_comb begin
    if (param_e < 0) begin
      t_in = '0;
    end else if (param_e > ONE_E) begin
      t_in = ONE_T;
    end else begin
      t_in = param_e[TW-1:0];
    end
  end

  assign epar   = PEW'(t_r) * PEW'(scale);
  assign pa_raw = CNT_W'(epar >> FRAC_BITS);
  assign pb_raw = {1'b0, pa_raw} + (CNT_W+1)'(|epar[FRAC_BITS-1:0]);

  always_comb begin
    pa = (pa_raw >= n_m1) ? n_m1 : pa_raw;
    if (pb_raw >= {1'b0, n_pts}) begin
      pb = closed_r ? '0 : n_m1;
    end else begin
      pb = pb_raw[CNT_W-1:0];
    end
  end

  assign f_full = epar - (PEW'(pa) << FRAC_BITS);
  assign f_seg  = f_full[TW-1:0];
  assign idx_ok = CNT_W'(idx_r) < n_pts;

  assign rd_en  = (state_r == S_ADDR);
  assign wr_en  = (state_r == S_ADDR) && (act_r == ACT_WRITE) && idx_ok;
  assign addr_a = (act_r == ACT_EVAL) ? AW'(pa) : AW'(idx_r);
  assign addr_b = AW'(pb);

  pli_point_mem #(
    .DEPTH(POINTS_MAX)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (AW'(idx_r)),
    .wr_data   (wpt_r),
    .rd_en     (rd_en),
    .rd_addr_a (addr_a),
    .rd_addr_b (addr_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  pli_blend #(.FRAC_BITS(FRAC_BITS)) u_blend_x (
    .clk(clk), .mul_en(state_r == S_MUL), .a(rd_a.x), .b(rd_b.x), .f(f_r), .pos(blend_pt.x)
  );

  pli_blend #(.FRAC_BITS(FRAC_BITS)) u_blend_y (
    .clk(clk), .mul_en(state_r == S_MUL), .a(rd_a.y), .b(rd_b.y), .f(f_r), .pos(blend_pt.y)
  );

  pli_blend #(.FRAC_BITS(FRAC_BITS)) u_blend_z (
    .clk(clk), .mul_en(state_r == S_MUL), .a(rd_a.z), .b(rd_b.z), .f(f_r), .pos(blend_pt.z)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_ADDR;
        end
      end
      S_ADDR:  state_nxt = S_MUL;
      S_MUL:   state_nxt = S_DONE;
      S_DONE: begin
        if (load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_pt_nxt     = '0;
    out_status_nxt = 1'b0;
    case (act_r)
      ACT_EVAL: begin
        out_pt_nxt = blend_pt;
      end
      ACT_READ: begin
        out_pt_nxt     = idx_ok ? rd_a : '0;
        out_status_nxt = !idx_ok;
      end
      ACT_WRITE: begin
        out_status_nxt = !idx_ok;
      end
      default: begin
        out_pt_nxt     = '0;
        out_status_nxt = 1'b0;
      end
    endcase
  end

  assign out_valid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      num_points_r <= CNT_W'(1);
      closed_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_NUM_POINTS: num_points_r <= cfg_data;
          REG_CLOSED:     closed_r     <= cfg_data[0];
          default:        closed_r     <= closed_r;
        endcase
      end
    end
    if (load) begin
      out_pt_r     <= out_pt_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r   <= in_tuser;
      idx_r   <= in_tdata[5:0];
      wpt_r.x <= in_tdata[37:6];
      wpt_r.y <= in_tdata[69:38];
      wpt_r.z <= in_tdata[101:70];
      t_r     <= t_in;
    end
    if (state_r == S_ADDR) begin
      f_r <= f_seg;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pt_r;
  assign out_tuser  = out_status_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_ADDR)
    else $error("accepted request did not start the address step");

  a_seg_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADDR && act_r == ACT_EVAL) |-> (pa < n_pts && pb < n_pts))
    else $error("segment endpoint outside the points in use");

  a_frac_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADDR && act_r == ACT_EVAL) |-> f_seg <= ONE_T)
    else $error("segment fraction above one");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_tvalid)
    else $error("loaded result not presented");

  a_done_path: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> ($past(state_r) == S_MUL || $past(state_r) == S_DONE))
    else $error("result step entered without multiply step");

endmodule

[test/polyline_point_interpolator_tb.sv]
`timescale 1ns / 100ps

module polyline_point_interpolator_tb;
  import pli_pkg::*;

  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;
  localparam longint ONE = longint'(1) << FRAC_BITS_DEF;
  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;
  localparam int HOLD_CYCLES = 400;
  localparam int LIMIT_CYCLES = 300000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic [ACT_W-1:0]          act;
    logic [INDEX_W-1:0]        idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic signed [PARAM_W-1:0] param;
  } pt_req_t;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      status;
  } pt_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [ACT_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0] cfg_data = '0;

  polyline_point_interpolator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Point table and registers as the block should hold them.
  logic signed [COORD_W-1:0] pt_x [POINTS_MAX_DEF];
  logic signed [COORD_W-1:0] pt_y [POINTS_MAX_DEF];
  logic signed [COORD_W-1:0] pt_z [POINTS_MAX_DEF];
  logic [CNT_W-1:0] cnt_reg = 7'd1;
  logic closed_reg = 1'b0;

  pt_req_t req_fifo[$];
  pt_res_t pending_pos[$];

  int queued_cnt = 0;
  int accepted_cnt = 0;
  int checked_cnt = 0;
  int err_cnt = 0;
  int cycle_cnt = 0;
  int write_cnt = 0;
  int read_cnt = 0;
  int eval_cnt = 0;
  int none_cnt = 0;
  int range_err_cnt = 0;
  int setting_cnt = 0;
  int hold_asked = 0;

  function automatic longint eff_count(logic [CNT_W-1:0] cnt);
    if (cnt == 0) return 1;
    if (cnt > POINTS_MAX_DEF) return longint'(POINTS_MAX_DEF);
    return longint'(cnt);
  endfunction

  function automatic logic signed [COORD_W-1:0] lerp_coord(logic signed [COORD_W-1:0] a,
                                                           logic signed [COORD_W-1:0] b,
                                                           longint f);
    longint s;
    s = ((longint'(a) * (ONE - f)) >>> FRAC_BITS_DEF) + ((longint'(b) * f) >>> FRAC_BITS_DEF);
    if (s > COORD_MAX) s = COORD_MAX;
    if (s < COORD_MIN) s = COORD_MIN;
    return s[COORD_W-1:0];
  endfunction

  function automatic pt_res_t interp_predict(pt_req_t r);
    pt_res_t res;
    longint n, t, scale, epar, pa, pb, f;
    res = '{x: '0, y: '0, z: '0, status: 1'b0};
    n = eff_count(cnt_reg);
    if (r.act == ACT_WRITE) begin
      write_cnt++;
      if (r.idx >= n) begin
        res.status = 1'b1;
      end else begin
        pt_x[r.idx] = r.x;
        pt_y[r.idx] = r.y;
        pt_z[r.idx] = r.z;
      end
    end else if (r.act == ACT_READ) begin
      read_cnt++;
      if (r.idx >= n) begin
        res.status = 1'b1;
      end else begin
        res.x = pt_x[r.idx];
        res.y = pt_y[r.idx];
        res.z = pt_z[r.idx];
      end
    end else if (r.act == ACT_EVAL) begin
      eval_cnt++;
      t = longint'(r.param);
      if (t < 0) t = 0;
      if (t > ONE) t = ONE;
      scale = closed_reg ? n : n - 1;
      epar = t * scale;
      pa = epar >>> FRAC_BITS_DEF;
      pb = ((epar & (ONE - 1)) != 0) ? pa + 1 : pa;
      if (pa >= n - 1) pa = n - 1;
      if (pb >= n) pb = closed_reg ? 0 : n - 1;
      f = epar - (pa << FRAC_BITS_DEF);
      res.x = lerp_coord(pt_x[pa], pt_x[pb], f);
      res.y = lerp_coord(pt_y[pa], pt_y[pb], f);
      res.z = lerp_coord(pt_z[pa], pt_z[pb], f);
    end else begin
      none_cnt++;
    end
    if (res.status) range_err_cnt++;
    return res;
  endfunction

  // Request driver: bursts of random length separated by random gaps.
  logic in_acc = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  pt_req_t drv_req;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_acc) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (req_fifo.size() > 0) begin
        drv_req = req_fifo.pop_front();
        in_tdata <= {drv_req.param, drv_req.z, drv_req.y, drv_req.x, drv_req.idx};
        in_tuser <= drv_req.act;
        in_tvalid <= 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end else begin
          burst_left--;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: changing stall modes plus requested long hold-offs.
  int hold_served = 0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int rx_tick = 0;

  always @(negedge clk) begin
    rx_tick++;
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_served != hold_asked) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= (rx_tick % 4 == 0);
      endcase
    end
  end

  // Monitor: predicts each accepted request and checks each accepted result.
  pt_req_t mon_req;
  pt_res_t mon_exp;
  logic signed [COORD_W-1:0] got_x, got_y, got_z;

  always @(posedge clk) begin
    cycle_cnt++;
    in_acc <= in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        mon_req.act = in_tuser;
        mon_req.idx = in_tdata[INDEX_W-1:0];
        mon_req.x = in_tdata[INDEX_W +: COORD_W];
        mon_req.y = in_tdata[INDEX_W + COORD_W +: COORD_W];
        mon_req.z = in_tdata[INDEX_W + 2*COORD_W +: COORD_W];
        mon_req.param = in_tdata[INDEX_W + 3*COORD_W +: PARAM_W];
        pending_pos.push_back(interp_predict(mon_req));
        accepted_cnt++;
      end
      if (out_tvalid && out_tready) begin
        got_x = out_tdata[0 +: COORD_W];
        got_y = out_tdata[COORD_W +: COORD_W];
        got_z = out_tdata[2*COORD_W +: COORD_W];
        if (pending_pos.size() == 0) begin
          $error("Result with no request outstanding: x %h y %h z %h status %0d",
                 got_x, got_y, got_z, out_tuser);
          err_cnt++;
        end else begin
          mon_exp = pending_pos.pop_front();
          checked_cnt++;
          if (got_x !== mon_exp.x) begin
            $error("pos_x: expected %h, got %h", mon_exp.x, got_x);
            err_cnt++;
          end
          if (got_y !== mon_exp.y) begin
            $error("pos_y: expected %h, got %h", mon_exp.y, got_y);
            err_cnt++;
          end
          if (got_z !== mon_exp.z) begin
            $error("pos_z: expected %h, got %h", mon_exp.z, got_z);
            err_cnt++;
          end
          if (out_tuser !== mon_exp.status) begin
            $error("status: expected %0d, got %0d", mon_exp.status, out_tuser);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin
    wait (cycle_cnt >= LIMIT_CYCLES);
    $display("Timed out after %0d cycles with %0d results outstanding.",
             cycle_cnt, pending_pos.size());
    $display("simulation failed");
    $finish;
  end

  // Stimulus generation.
  longint gen_n = 1;
  logic [POINTS_MAX_DEF-1:0] written_mask = '0;

  function automatic void queue_req(logic [ACT_W-1:0] act, int idx,
                                    logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                    logic [COORD_W-1:0] z, logic [PARAM_W-1:0] param);
    pt_req_t r;
    r.act = act;
    r.idx = idx[INDEX_W-1:0];
    r.x = x;
    r.y = y;
    r.z = z;
    r.param = param;
    if (act == ACT_WRITE && idx < gen_n) written_mask[idx] = 1'b1;
    req_fifo.push_back(r);
    queued_cnt++;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [PARAM_W-1:0] rand_param(longint scale);
    longint k;
    case ($urandom_range(0, 5))
      0: return PARAM_W'($urandom);
      1: begin
        if (scale == 0) return '0;
        k = longint'($urandom_range(0, scale));
        return PARAM_W'((k << FRAC_BITS_DEF) / scale);
      end
      2: begin
        case ($urandom_range(0, 6))
          0: return 18'sd0;
          1: return 18'sd65536;
          2: return -18'sd1;
          3: return 18'sd131071;
          4: return 18'h20000;
          5: return 18'sd1;
          default: return 18'sd65535;
        endcase
      end
      default: return PARAM_W'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic wait_idle();
    do @(negedge clk); while (accepted_cnt != queued_cnt || pending_pos.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_NUM_POINTS) cnt_reg = val;
    else closed_reg = val[0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int cnt_val, bit closed_val, int n_items, bit with_hold);
    int sel, idx;
    longint scale;
    wait_idle();
    write_reg(REG_NUM_POINTS, CNT_W'(cnt_val));
    write_reg(REG_CLOSED, CNT_W'(closed_val));
    setting_cnt++;
    gen_n = eff_count(CNT_W'(cnt_val));
    scale = closed_val ? gen_n : gen_n - 1;
    for (int i = 0; i < gen_n; i++) begin
      if (!written_mask[i]) queue_req(ACT_WRITE, i, rand_coord(), rand_coord(), rand_coord(),
                                      PARAM_W'($urandom));
    end
    if (with_hold) hold_asked++;
    for (int i = 0; i < n_items; i++) begin
      sel = $urandom_range(0, 19);
      idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, POINTS_MAX_DEF - 1)
                                        : $urandom_range(0, gen_n - 1);
      if (sel < 4) queue_req(ACT_WRITE, idx, rand_coord(), rand_coord(), rand_coord(),
                             PARAM_W'($urandom));
      else if (sel < 8) queue_req(ACT_READ, idx, $urandom, $urandom, $urandom,
                                  PARAM_W'($urandom));
      else if (sel < 19) queue_req(ACT_EVAL, $urandom, $urandom, $urandom, $urandom,
                                   rand_param(scale));
      else queue_req(ACT_NONE, $urandom, $urandom, $urandom, $urandom, PARAM_W'($urandom));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Single open point after reset: range errors, clamps and the unused action.
    queue_req(ACT_WRITE, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, '0);
    queue_req(ACT_READ, 0, '0, '0, '0, '0);
    queue_req(ACT_WRITE, 1, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333, '0);
    queue_req(ACT_READ, 63, '0, '0, '0, '0);
    queue_req(ACT_WRITE, 63, '1, '1, '1, '1);
    queue_req(ACT_EVAL, 0, '0, '0, '0, 18'sd0);
    queue_req(ACT_EVAL, 0, '0, '0, '0, 18'h20000);
    queue_req(ACT_EVAL, 0, '0, '0, '0, 18'sd131071);
    queue_req(ACT_NONE, 63, '1, '1, '1, '1);

    wait_idle();
    write_reg(REG_NUM_POINTS, 7'd4);
    setting_cnt++;
    gen_n = 4;
    queue_req(ACT_WRITE, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, '0);
    queue_req(ACT_WRITE, 1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, '0);
    queue_req(ACT_WRITE, 2, 32'h0000_0000, 32'h7FFF_0000, 32'h0000_8000, '0);
    queue_req(ACT_WRITE, 3, 32'hFFFF_0000, 32'h0001_0000, 32'h1234_5678, '0);
    queue_req(ACT_EVAL, 0, '0, '0, '0, 18'sd0);
    queue_req(ACT_EVAL, 0, '0, '0, '0, 18'sd32768);
    queue_req(ACT_EVAL, 0, '0, '0, '0, 18'sd65536);
    queue_req(ACT_EVAL, 0, '0, '0, '0, 18'sd21845);
    queue_req(ACT_EVAL, 0, '0, '0, '0, -18'sd1);
    queue_req(ACT_READ, 3, '0, '0, '0, '0);
    queue_req(ACT_READ, 4, '0, '0, '0, '0);

    // Closing the curve makes the last segment run back to point 0.
    wait_idle();
    write_reg(REG_CLOSED, 7'd1);
    setting_cnt++;
    queue_req(ACT_EVAL, 0, '0, '0, '0, 18'sd65536);
    queue_req(ACT_EVAL, 0, '0, '0, '0, 18'sd49152);
    queue_req(ACT_EVAL, 0, '0, '0, '0, 18'sd57344);
    queue_req(ACT_EVAL, 0, '0, '0, '0, 18'sd131071);

    run_phase(64, 1'b1, 60, 1'b1);
    run_phase(0, 1'b0, 80, 1'b0);
    run_phase(127, 1'b0, 90, 1'b0);
    run_phase(2, 1'b1, 80, 1'b0);
    run_phase(37, 1'b0, 90, 1'b1);
    run_phase(1, 1'b1, 60, 1'b0);
    run_phase(13, 1'b1, 90, 1'b0);
    run_phase(64, 1'b0, 56, 1'b0);
    run_phase(5, 1'b0, 80, 1'b0);
    run_phase($urandom_range(1, 64), 1'($urandom_range(0, 1)), 80, 1'b0);

    wait_idle();
    $display("Sent %0d writes, %0d reads, %0d evaluations and %0d unused-action requests.",
             write_cnt, read_cnt, eval_cnt, none_cnt);
    $display("Checked %0d results, %0d with range errors, over %0d register settings.",
             checked_cnt, range_err_cnt, setting_cnt);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/pli_pkg.sv
hw/rtl/pli_point_mem.sv
hw/rtl/pli_blend.sv
hw/rtl/polyline_point_interpolator.sv
test/polyline_point_interpolator_tb.sv
